// ----- design/fpfs_pkg.sv -----
// Package for the frame pacer: widths, register indexes, sequencer states
// and small helpers shared by the top level and the serial divider.
// No dependencies.
package fpfs_pkg;

  localparam int COUNT_BITS = 16;                 // frame counter width, 8..32
  localparam int TIME_W     = 32;
  localparam int FPS_W      = 10;
  localparam int SKIP_W     = 8;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 10;

  // dividend covers count*1000 and count*100
  localparam int DIV_W   = COUNT_BITS + 10;
  localparam int RHS_W   = FPS_W + TIME_W;
  localparam int CMP_W   = (DIV_W > RHS_W) ? DIV_W : RHS_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);

  localparam logic [TIME_W-1:0] MS_PER_SEC  = TIME_W'(1000);
  localparam logic [DIV_W-1:0]  FRAME_SCALE = DIV_W'(1000);
  localparam logic [DIV_W-1:0]  PCT_SCALE   = DIV_W'(100);
  localparam logic [OUT_W-1:0]  PCT_FULL    = OUT_W'(100);
  localparam logic [FPS_W-1:0]  FPS_RESET   = FPS_W'(25);
  localparam logic [SKIP_W-1:0] SKIP_RESET  = SKIP_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FPS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SKIP   = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_CMP,
    ST_DIV_DELAY,
    ST_REPORT,
    ST_DIV_SPEED,
    ST_FINISH
  } fpfs_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [FPS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [OUT_W-1:0] sat16(input logic [63:0] v);
    logic [63:0] lim;
    lim = 64'((1 << OUT_W) - 1);
    sat16 = (v > lim) ? OUT_W'(lim) : v[OUT_W-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] c);
    count_up = (c != '1) ? c + COUNT_BITS'(1) : c;
  endfunction

endpackage

// ----- design/fpfs_div.sv -----
// Restoring serial divider, one quotient bit per cycle, shared by the
// delay and speed computations. Depends on fpfs_pkg.
module fpfs_div
  import fpfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  quo;
  logic [FPS_W-1:0]  rem;
  logic [FPS_W-1:0]  dvsr;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [FPS_W:0]    rem_sh;
  logic              fits;

  always_comb begin
    rem_sh = {rem, quo[DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dvsr <= req.divisor;
        cnt  <= DCNT_W'(DIV_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? FPS_W'(rem_sh - {1'b0, dvsr}) : rem_sh[FPS_W-1:0];
        quo  <= {quo[DIV_W-2:0], fits};
        cnt  <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ----- design/frame_pacer_with_frameskip.sv -----
// Frame pacer with frameskip: top level with the sequencer, pacing state,
// result register and configuration registers.
// Depends on fpfs_pkg and fpfs_div.
//
// Usage: one beat on the input channel per video frame carries now_ms, the
// current time in ms (modular 32 bit). Each input beat yields exactly one
// output beat: first_frame, skip_frame, delay_ms, frame_time_ms, and the
// once-a-second report (report_valid, fps_measured, speed_percent).
// The target rate (index 0) and max_skip (index 1) are written on the cfg
// channel; cfg_ready is high only while the sequencer is idle, and a pending
// write holds off the input in that cycle. A write to either register clears
// all pacing state, so the next frame only opens the windows again.
// From accept the sequencer runs prep, then (started, nonzero target) multiply
// and compare, a delay division when the frame comes too fast, the report step,
// a speed division when a report is due with a nonzero target, and finish; a
// first frame goes from prep straight to finish, a zero target skips to report.
// All division goes through one serial divider, one quotient bit per cycle.
// One item is in work at a time: in_stall is high from accept until the result
// is loaded into the output register.
// The output register holds its beat while out_stall is high; a new item may
// be accepted meanwhile and waits in its last step until the register frees.
// Reset (rst, synchronous) restores the 25 fps target, max_skip=2, clears state.
module frame_pacer_with_frameskip
  import fpfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TIME_W-1:0]     now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  first_frame,
  output logic                  skip_frame,
  output logic [OUT_W-1:0]      delay_ms,
  output logic [OUT_W-1:0]      frame_time_ms,
  output logic                  report_valid,
  output logic [OUT_W-1:0]      fps_measured,
  output logic [OUT_W-1:0]      speed_percent,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fpfs_state_t state, state_next;

  // configuration
  logic [FPS_W-1:0]      fps_target;
  logic [SKIP_W-1:0]     max_skip;

  // pacing state
  logic                  started;
  logic [TIME_W-1:0]     sync_window_start;
  logic [COUNT_BITS-1:0] sync_frame_count;
  logic [SKIP_W-1:0]     skip_run;
  logic [TIME_W-1:0]     report_window_start;
  logic [COUNT_BITS-1:0] report_frame_count;
  logic [TIME_W-1:0]     previous_frame_time;

  // working registers
  logic [TIME_W-1:0]     now_r;
  logic [DIV_W-1:0]      lhs;
  logic [RHS_W-1:0]      rhs;
  logic                  res_first;
  logic [OUT_W-1:0]      res_delay;
  logic [OUT_W-1:0]      res_ftime;
  logic                  res_report;
  logic [OUT_W-1:0]      res_fps;
  logic [OUT_W-1:0]      res_speed;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CMP_W-1:0]      lhs_x, rhs_x;
  logic                  too_fast, on_rate;
  logic                  report_due;
  logic                  out_free;
  logic                  in_accept, cfg_write;
  logic [OUT_W-1:0]      q_sat;
  logic [TIME_W-1:0]     frame_gap, sync_elapsed;

  assign cfg_ready = (state == ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_write = cfg_valid && cfg_ready;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    lhs_x        = CMP_W'(lhs);
    rhs_x        = CMP_W'(rhs);
    on_rate      = lhs_x == rhs_x;
    too_fast     = lhs_x > rhs_x;
    report_due   = (now_r - report_window_start) >= MS_PER_SEC;
    q_sat        = sat16(64'(div_rsp.quotient));
    // modular 32-bit differences
    frame_gap    = now_r - previous_frame_time;
    sync_elapsed = now_r - sync_window_start;
  end

  fpfs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_stall         = 1'b1;
    div_req.start    = 1'b0;
    div_req.divisor  = fps_target;
    div_req.dividend = DIV_W'(lhs_x - rhs_x);
    unique case (state)
      ST_IDLE: begin
        // a pending register write goes first
        in_stall = cfg_valid;
        if (in_accept) state_next = ST_PREP;
      end
      ST_PREP: begin
        if (!started)               state_next = ST_FINISH;
        else if (fps_target != '0)  state_next = ST_MUL;
        else                        state_next = ST_REPORT;
      end
      ST_MUL: state_next = ST_CMP;
      ST_CMP: begin
        if (!on_rate && too_fast) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_DELAY;
        end else begin
          state_next = ST_REPORT;
        end
      end
      ST_DIV_DELAY: begin
        if (div_rsp.done) state_next = ST_REPORT;
      end
      ST_REPORT: begin
        div_req.dividend = DIV_W'(report_frame_count) * PCT_SCALE;
        if (report_due && fps_target != '0) begin
          div_req.start = 1'b1;
          state_next    = ST_DIV_SPEED;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIV_SPEED: begin
        if (div_rsp.done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fps_target          <= FPS_RESET;
      max_skip            <= SKIP_RESET;
      started             <= 1'b0;
      sync_window_start   <= '0;
      sync_frame_count    <= '0;
      skip_run            <= '0;
      report_window_start <= '0;
      report_frame_count  <= '0;
      previous_frame_time <= '0;
      out_valid           <= 1'b0;
    end else begin
      if (state == ST_FINISH && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)   out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_accept) now_r <= now_ms;
        end
        ST_PREP: begin
          res_first  <= !started;
          res_delay  <= '0;
          res_report <= 1'b0;
          res_fps    <= '0;
          res_speed  <= '0;
          if (!started) begin
            started             <= 1'b1;
            sync_window_start   <= now_r;
            report_window_start <= now_r;
            sync_frame_count    <= '0;
            report_frame_count  <= '0;
            skip_run            <= '0;
            previous_frame_time <= now_r;
            res_ftime           <= '0;
          end else begin
            res_ftime          <= sat16(64'(frame_gap));
            report_frame_count <= count_up(report_frame_count);
            if (fps_target != '0) sync_frame_count <= count_up(sync_frame_count);
          end
        end
        ST_MUL: begin
          lhs <= DIV_W'(sync_frame_count) * FRAME_SCALE;
          rhs <= RHS_W'(fps_target) * RHS_W'(sync_elapsed);
        end
        ST_CMP: begin
          if (on_rate) begin
            sync_window_start <= now_r;
            sync_frame_count  <= '0;
            skip_run          <= '0;
          end else if (too_fast) begin
            skip_run <= '0;
          end else if (skip_run < max_skip) begin
            skip_run <= skip_run + SKIP_W'(1);
          end else begin
            // skipped enough: give up catching up and restart the window
            sync_window_start <= now_r;
            sync_frame_count  <= '0;
            skip_run          <= '0;
          end
        end
        ST_DIV_DELAY: begin
          if (div_rsp.done) begin
            // delay assumed honored exactly
            res_delay <= q_sat;
            now_r     <= now_r + TIME_W'(q_sat);
          end
        end
        ST_REPORT: begin
          previous_frame_time <= now_r;
          if (report_due) begin
            res_report          <= 1'b1;
            res_fps             <= sat16(64'(report_frame_count));
            res_speed           <= PCT_FULL;
            report_window_start <= now_r;
            report_frame_count  <= '0;
          end
        end
        ST_DIV_SPEED: begin
          if (div_rsp.done) res_speed <= q_sat;
        end
        ST_FINISH: begin
          if (out_free) begin
            first_frame   <= res_first;
            skip_frame    <= skip_run != '0;
            delay_ms      <= res_delay;
            frame_time_ms <= res_ftime;
            report_valid  <= res_report;
            fps_measured  <= res_fps;
            speed_percent <= res_speed;
          end
        end
        default: ;
      endcase

      if (cfg_write && (cfg_index == CFG_TARGET_FPS || cfg_index == CFG_MAX_SKIP)) begin
        if (cfg_index == CFG_TARGET_FPS) fps_target <= cfg_data[FPS_W-1:0];
        else                             max_skip   <= cfg_data[SKIP_W-1:0];
        started             <= 1'b0;
        sync_window_start   <= '0;
        sync_frame_count    <= '0;
        skip_run            <= '0;
        report_window_start <= '0;
        report_frame_count  <= '0;
        previous_frame_time <= '0;
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != ST_IDLE)
    else $error("accepted beat did not start the sequencer");

  a_div_start_place: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (state == ST_CMP || state == ST_REPORT) && fps_target != '0)
    else $error("divider started outside its steps or with zero divisor");

  a_skip_bound: assert property (@(posedge clk) disable iff (rst)
    skip_run <= max_skip)
    else $error("skip run exceeds skip limit");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV_DELAY || state == ST_DIV_SPEED)
    else $error("divider result with no step waiting for it");

endmodule

// ----- verif/tb_frame_pacer_with_frameskip.sv -----
// Self-checking bench for frame_pacer_with_frameskip: random frame timestamps,
// register writes between phases, predicted pacing results checked per beat.
// Depends on fpfs_pkg and the frame_pacer_with_frameskip RTL.
`timescale 1ns / 100ps

module tb_frame_pacer_with_frameskip;
  import fpfs_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int RANDOM_ITEMS  = 550;

  typedef struct packed {
    logic             first_frame;
    logic             skip_frame;
    logic [OUT_W-1:0] delay_ms;
    logic [OUT_W-1:0] frame_time_ms;
    logic             report_valid;
    logic [OUT_W-1:0] fps_measured;
    logic [OUT_W-1:0] speed_percent;
  } pacer_result_t;

  // Predicts the pacer's beats and checks them in order.
  class pacer_scoreboard;
    logic [FPS_W-1:0]      target;
    logic [SKIP_W-1:0]     skip_limit;
    logic                  armed;
    logic [TIME_W-1:0]     win_start;
    logic [COUNT_BITS-1:0] win_frames;
    logic [SKIP_W-1:0]     skip_streak;
    logic [TIME_W-1:0]     rpt_start;
    logic [COUNT_BITS-1:0] rpt_frames;
    logic [TIME_W-1:0]     last_frame_ms;
    logic [TIME_W-1:0]     resume_ms;     // frame time after an honored delay
    pacer_result_t         expected_beats[$];
    int                    errors;

    function new();
      target = FPS_RESET;
      skip_limit = SKIP_RESET;
      errors = 0;
      resume_ms = '0;
      clear_pacing();
    endfunction

    function void clear_pacing();
      armed = 1'b0;
      win_start = '0;
      win_frames = '0;
      skip_streak = '0;
      rpt_start = '0;
      rpt_frames = '0;
      last_frame_ms = '0;
    endfunction

    function logic [OUT_W-1:0] clamp16(input logic [63:0] v);
      return (v > 64'd65535) ? '1 : v[OUT_W-1:0];
    endfunction

    function logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_TARGET_FPS) begin
        target = data[FPS_W-1:0];
        clear_pacing();
      end else if (idx == CFG_MAX_SKIP) begin
        skip_limit = data[SKIP_W-1:0];
        clear_pacing();
      end
    endfunction

    function void note_frame(input logic [TIME_W-1:0] t);
      pacer_result_t r;
      logic [TIME_W-1:0] t_eff, gap32, span32, since_rpt;
      logic [63:0] lhs, rhs;
      r = '0;
      t_eff = t;
      if (!armed) begin
        armed = 1'b1;
        win_start = t;
        rpt_start = t;
        win_frames = '0;
        rpt_frames = '0;
        skip_streak = '0;
        last_frame_ms = t;
        r.first_frame = 1'b1;
      end else begin
        gap32 = t - last_frame_ms;
        r.frame_time_ms = clamp16({32'b0, gap32});
        rpt_frames = bump(rpt_frames);
        if (target != 0) begin
          win_frames = bump(win_frames);
          span32 = t - win_start;
          lhs = 64'(win_frames) * 64'd1000;
          rhs = 64'(target) * {32'b0, span32};
          if (lhs == rhs || (lhs < rhs && skip_streak >= skip_limit)) begin
            win_start = t;
            win_frames = '0;
            skip_streak = '0;
          end else if (lhs > rhs) begin
            // delay assumed honored: time moves on by the clamped delay
            r.delay_ms = clamp16((lhs - rhs) / 64'(target));
            t_eff = t + {16'b0, r.delay_ms};
            skip_streak = '0;
          end else begin
            skip_streak = skip_streak + 1'b1;
          end
        end
        since_rpt = t_eff - rpt_start;
        if (since_rpt >= 32'd1000) begin
          r.report_valid = 1'b1;
          r.fps_measured = clamp16(64'(rpt_frames));
          r.speed_percent = (target != 0) ?
              clamp16(64'(rpt_frames) * 64'd100 / 64'(target)) : 16'd100;
          rpt_start = t_eff;
          rpt_frames = '0;
        end
        last_frame_ms = t_eff;
        r.skip_frame = (skip_streak != 0);
      end
      resume_ms = t_eff;
      expected_beats.push_back(r);
    endfunction

    function void cmp_field(input string name, input logic [OUT_W-1:0] want,
                            input logic [OUT_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(input pacer_result_t got);
      pacer_result_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      cmp_field("first_frame", OUT_W'(want.first_frame), OUT_W'(got.first_frame));
      cmp_field("skip_frame", OUT_W'(want.skip_frame), OUT_W'(got.skip_frame));
      cmp_field("delay_ms", want.delay_ms, got.delay_ms);
      cmp_field("frame_time_ms", want.frame_time_ms, got.frame_time_ms);
      cmp_field("report_valid", OUT_W'(want.report_valid), OUT_W'(got.report_valid));
      cmp_field("fps_measured", want.fps_measured, got.fps_measured);
      cmp_field("speed_percent", want.speed_percent, got.speed_percent);
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TIME_W-1:0]     now_ms = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  first_frame;
  logic                  skip_frame;
  logic [OUT_W-1:0]      delay_ms;
  logic [OUT_W-1:0]      frame_time_ms;
  logic                  report_valid;
  logic [OUT_W-1:0]      fps_measured;
  logic [OUT_W-1:0]      speed_percent;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pacer_scoreboard sb = new();
  bit calm = 1'b0;          // phase with no idling on either side
  int random_items = 0;
  int hold_left = 0;

  frame_pacer_with_frameskip uut (.*);

  always #5 clk = ~clk;

  initial begin
    #10ms;
    $display("frame_pacer_with_frameskip regression: fail");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      hold_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_beat('{first_frame, skip_frame, delay_ms, frame_time_ms,
                      report_valid, fps_measured, speed_percent});
  end

  task automatic send_frame(input logic [TIME_W-1:0] t);
    int idle;
    in_valid <= 1'b1;
    now_ms <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_frame(t);
    idle = pick_gap();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // registers only change once the pacer has drained
  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.apply_reg(idx, data);
  endtask

  // burst: frozen clock at a tiny target drives the delay up, to saturation at 1 fps
  task automatic random_phase(input bit burst);
    logic [CFG_DATA_W-1:0] tgt, skp;
    logic [TIME_W-1:0] t;
    int n, period, step, r;
    case ($urandom_range(0, 9))
      0: tgt = '0;
      1: tgt = CFG_DATA_W'(1);
      2: tgt = CFG_DATA_W'(1000);
      3: tgt = CFG_DATA_W'($urandom_range(1001, 1023));
      4, 5: tgt = CFG_DATA_W'($urandom_range(1, 1023));
      default: tgt = CFG_DATA_W'($urandom_range(20, 60));
    endcase
    if (burst) tgt = CFG_DATA_W'($urandom_range(1, 3));
    case ($urandom_range(0, 5))
      0: skp = '0;
      1: skp = '1;
      2: skp = CFG_DATA_W'(SKIP_RESET);
      default: skp = CFG_DATA_W'($urandom_range(0, 1023));
    endcase
    if ($urandom_range(0, 1)) begin
      program_reg(CFG_TARGET_FPS, tgt);
      program_reg(CFG_MAX_SKIP, skp);
    end else begin
      program_reg(CFG_MAX_SKIP, skp);
      program_reg(CFG_TARGET_FPS, tgt);
    end
    if ($urandom_range(0, 7) == 0)
      program_reg(CFG_IDX_W'($urandom_range(CFG_MAX_SKIP + 1, 2 ** CFG_IDX_W - 1)),
                  CFG_DATA_W'($urandom));
    calm = ($urandom_range(0, 3) == 0);
    period = (tgt == 0) ? $urandom_range(10, 50) : (tgt >= 1000) ? 1 : 1000 / tgt;
    t = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2000) : $urandom;
    send_frame(t);
    n = burst ? $urandom_range(70, 90) : $urandom_range(15, 70);
    repeat (n) begin
      r = burst ? -1 : $urandom_range(0, 99);
      if (r < 0) begin
        // same timestamp again
      end else if (r < 65) begin
        step = period + $urandom_range(0, 4) - 2;
        if (step < 0) step = 0;
        t = sb.resume_ms + step;
      end else if (r < 75) begin
        t = sb.resume_ms + period * $urandom_range(2, 6);
      end else if (r < 85) begin
        t = t + $urandom_range(0, period / 2);       // delay not honored
      end else if (r < 90) begin
        // repeat
      end else if (r < 95) begin
        t = sb.resume_ms + $urandom_range(1000, 3000);
      end else if (r < 98) begin
        t = sb.resume_ms + $urandom_range(65536, 200000);
      end else begin
        t = $urandom;
      end
      send_frame(t);
      random_items++;
    end
  endtask

  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: 25 fps, skip up to 2
    send_frame(0);
    send_frame(40);          // exactly on rate
    send_frame(40);          // zero elapsed counts as too fast
    send_frame(200);
    send_frame(400);
    send_frame(600);         // skip limit reached, window restarts
    send_frame(1100);        // report
    send_frame(1100 + 65600); // frame time saturates
    program_reg(CFG_IDX_W'(2 ** CFG_IDX_W - 1), '1);   // unused index leaves state alone
    send_frame(1100 + 65640);

    program_reg(CFG_TARGET_FPS, '0);
    send_frame(32'hFFFF_FFFF);
    send_frame(32'h0000_0000);
    send_frame(999);         // report at exactly one second, speed fixed at 100

    program_reg(CFG_TARGET_FPS, '1);       // largest target the register holds
    program_reg(CFG_MAX_SKIP, '1);
    send_frame(5000);
    send_frame(5000);
    send_frame(5001);
    send_frame(5003);

    program_reg(CFG_TARGET_FPS, CFG_DATA_W'(1));
    program_reg(CFG_MAX_SKIP, '0);
    send_frame(32'hFFFF_FF00);
    send_frame(32'hFFFF_FF00);              // delay wraps time past zero
    send_frame(sb.resume_ms + 5000);        // slow with no skips allowed

    program_reg(CFG_TARGET_FPS, CFG_DATA_W'(1000));
    program_reg(CFG_MAX_SKIP, 10'h0FF);
    send_frame(10);
    send_frame(11);
    send_frame(11);

    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      random_phase(phase == 1);
      phase++;
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("frame_pacer_with_frameskip regression: pass");
    else
      $display("frame_pacer_with_frameskip regression: fail");
    $finish;
  end

endmodule
